>>> sv/dq_pkg.sv
// Shared types and constants of the double-ended queue unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package dq_pkg;

  // Default sizes of the store.
  localparam int DQ_DEPTH      = 16;
  localparam int DQ_VALUE_BITS = 32;

  // Fixed widths of the request and result fields.
  localparam int DQ_VAL_W = 32;
  localparam int DQ_LEN_W = 5;
  localparam int DQ_OP_W  = 3;
  localparam int DQ_ST_W  = 2;

  // Operation codes of a request.
  typedef enum logic [DQ_OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_REMOVE     = 3'd4
  } op_code_t;

  // Status codes of a result.
  typedef enum logic [DQ_ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RD_FRONT,
    S_RD_BOTH,
    S_RD_BACK
  } dq_state_t;

  // Update of the search index.
  typedef enum logic [1:0] {
    K_HOLD,
    K_ZERO,
    K_INC
  } k_op_t;

  // Logical position that the store read addresses.
  typedef enum logic [1:0] {
    RS_FRONT,
    RS_BACK,
    RS_K,
    RS_K1
  } rd_sel_t;

  // One request.
  typedef struct packed {
    logic [DQ_OP_W-1:0]  opcode;
    logic [DQ_VAL_W-1:0] item_value;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [DQ_VAL_W-1:0] out_value;
    logic [DQ_ST_W-1:0]  status;
    logic [DQ_LEN_W-1:0] length;
    logic [DQ_VAL_W-1:0] front_value;
    logic [DQ_VAL_W-1:0] back_value;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    push_back;
    logic    push_front;
    logic    pop_back;
    logic    pop_front;
    logic    st_set;
    status_t st_val;
    logic    res_set;
    k_op_t   k_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    shift_wr;
    logic    rm_dec;
    logic    ld_front;
    logic    ld_back;
    logic    finish;
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [DQ_OP_W-1:0] opcode;
    logic               empty;
    logic               full;
    logic               cnt_one;
    logic               match;
    logic               k_last;
  } dq_stat_t;

endpackage

`default_nettype wire

>>> sv/dq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/dq_datapath.sv
// Datapath of the double-ended queue: ring pointers, count, cached end values,
// search index, result register and the entry store. Depends on dq_pkg, dq_ram.
`default_nettype none

module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH      = DQ_DEPTH,
  parameter int VALUE_BITS = DQ_VALUE_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_item,
  input  wire dq_cmd_t   cmd,
  output dq_stat_t       stat,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VB = VALUE_BITS;

  // Ring position of logical offset off from base, with one wrap at most.
  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // A stored value on a result field: low bits, zero-extended.
  function automatic logic [DQ_VAL_W-1:0] to_port(logic [VB-1:0] x);
    logic [VB+DQ_VAL_W-1:0] t;
    t = {{DQ_VAL_W{1'b0}}, x};
    return t[DQ_VAL_W-1:0];
  endfunction

  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  front_idx_r, front_idx_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  logic [VB-1:0]  value_r, value_nxt;
  logic [VB-1:0]  res_r, res_nxt;
  status_t        st_r, st_nxt;
  logic [VB-1:0]  front_r, front_nxt;
  logic [VB-1:0]  back_r, back_nxt;
  out_item_t      out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [VB+DQ_VAL_W-1:0] in_wide;
  logic [VB-1:0]          v_in;
  logic [CW+DQ_LEN_W-1:0] len_wide;
  logic [AW-1:0]          fidx_dec;
  logic [CW-1:0]          rd_off;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [VB-1:0]  ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [VB-1:0]  ram_rdata;

  // Request value kept in its low VALUE_BITS bits.
  assign in_wide = {{VB{1'b0}}, in_item.item_value};
  assign v_in    = in_wide[VB-1:0];

  // Front position after a push to the front.
  assign fidx_dec = (front_idx_r == '0) ? AW'(DEPTH - 1) : front_idx_r - AW'(1);

  // Status toward the controller.
  assign stat.opcode  = in_item.opcode;
  assign stat.empty   = (count_r == '0);
  assign stat.full    = (count_r == CW'(DEPTH));
  assign stat.cnt_one = (count_r == CW'(1));
  assign stat.match   = (ram_rdata == value_r);
  assign stat.k_last  = ((k_r + CW'(1)) == count_r);

  // Next values of the datapath registers and the store write.
  always_comb begin
    count_nxt     = count_r;
    front_idx_nxt = front_idx_r;
    k_nxt         = k_r;
    value_nxt     = value_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = slot_of(front_idx_r, k_r);
    ram_wdata     = ram_rdata;
    len_wide      = '0;

    if (cmd.accept) begin
      value_nxt = v_in;
      res_nxt   = '0;
      st_nxt    = ST_OK;
    end

    // End operations decided at acceptance.
    if (cmd.push_back) begin
      count_nxt = count_r + CW'(1);
      back_nxt  = v_in;
      if (count_r == '0) begin
        front_nxt = v_in;
      end
      ram_we    = 1'b1;
      ram_waddr = slot_of(front_idx_r, count_r);
      ram_wdata = v_in;
    end else if (cmd.push_front) begin
      count_nxt     = count_r + CW'(1);
      front_idx_nxt = fidx_dec;
      front_nxt     = v_in;
      if (count_r == '0) begin
        back_nxt = v_in;
      end
      ram_we    = 1'b1;
      ram_waddr = fidx_dec;
      ram_wdata = v_in;
    end else if (cmd.shift_wr) begin
      // Close the gap: the entry read last cycle moves one place forward.
      ram_we    = 1'b1;
      ram_waddr = slot_of(front_idx_r, k_r);
      ram_wdata = ram_rdata;
    end

    if (cmd.pop_back) begin
      count_nxt = count_r - CW'(1);
      res_nxt   = back_r;
    end
    if (cmd.pop_front) begin
      count_nxt     = count_r - CW'(1);
      res_nxt       = front_r;
      front_idx_nxt = slot_of(front_idx_r, CW'(1));
    end
    if (cmd.rm_dec) begin
      count_nxt = count_r - CW'(1);
    end

    if (cmd.st_set) begin
      st_nxt = cmd.st_val;
    end
    if (cmd.res_set) begin
      res_nxt = value_r;
    end

    // Search index.
    unique case (cmd.k_op)
      K_ZERO:  k_nxt = '0;
      K_INC:   k_nxt = k_r + CW'(1);
      default: k_nxt = k_r;
    endcase

    // Refresh of the cached end values from the store.
    if (cmd.ld_front) begin
      front_nxt = ram_rdata;
    end
    if (cmd.ld_back) begin
      back_nxt = ram_rdata;
    end

    // Result register.
    if (cmd.finish) begin
      len_wide              = {{DQ_LEN_W{1'b0}}, count_nxt};
      out_valid_nxt         = 1'b1;
      out_nxt.out_value     = to_port(res_nxt);
      out_nxt.status        = st_nxt;
      out_nxt.length        = len_wide[DQ_LEN_W-1:0];
      out_nxt.front_value   = (count_nxt == '0) ? '0 : to_port(front_nxt);
      out_nxt.back_value    = (count_nxt == '0) ? '0 : to_port(back_nxt);
    end
  end

  // Read address, taken from the next values of the pointers.
  always_comb begin
    unique case (cmd.rd_sel)
      RS_FRONT: rd_off = '0;
      RS_BACK:  rd_off = count_nxt - CW'(1);
      RS_K:     rd_off = k_nxt;
      default:  rd_off = k_nxt + CW'(1);
    endcase
    ram_raddr = slot_of(front_idx_nxt, rd_off);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      front_idx_r <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      st_r        <= ST_OK;
    end else begin
      count_r     <= count_nxt;
      front_idx_r <= front_idx_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    res_r   <= res_nxt;
    front_r <= front_nxt;
    back_r  <= back_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Entry store.
  dq_ram #(
    .WIDTH (VB),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

>>> sv/dq_ctrl.sv
// Controller state machine of the double-ended queue: sequences pushes, pops,
// the search and compaction of remove, and refreshes of the end values. Depends on dq_pkg.
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dq_stat_t stat,
  output logic          busy,
  output dq_cmd_t       cmd
);

  dq_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.st_val = ST_OK;
    cmd.k_op   = K_HOLD;
    cmd.rd_sel = RS_FRONT;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          unique case (stat.opcode)
            OP_PUSH_BACK: begin
              if (stat.full) begin
                cmd.st_set = 1'b1;
                cmd.st_val = ST_FULL;
              end else begin
                cmd.push_back = 1'b1;
              end
              cmd.finish = 1'b1;
            end
            OP_PUSH_FRONT: begin
              if (stat.full) begin
                cmd.st_set = 1'b1;
                cmd.st_val = ST_FULL;
              end else begin
                cmd.push_front = 1'b1;
              end
              cmd.finish = 1'b1;
            end
            OP_POP_BACK: begin
              if (stat.empty) begin
                cmd.st_set = 1'b1;
                cmd.st_val = ST_EMPTY;
                cmd.finish = 1'b1;
              end else if (stat.cnt_one) begin
                cmd.pop_back = 1'b1;
                cmd.finish   = 1'b1;
              end else begin
                cmd.pop_back = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RS_BACK;
                state_nxt    = S_RD_BACK;
              end
            end
            OP_POP_FRONT: begin
              if (stat.empty) begin
                cmd.st_set = 1'b1;
                cmd.st_val = ST_EMPTY;
                cmd.finish = 1'b1;
              end else if (stat.cnt_one) begin
                cmd.pop_front = 1'b1;
                cmd.finish    = 1'b1;
              end else begin
                cmd.pop_front = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RS_FRONT;
                state_nxt     = S_RD_FRONT;
              end
            end
            OP_REMOVE: begin
              if (stat.empty) begin
                cmd.st_set = 1'b1;
                cmd.st_val = ST_NOT_FOUND;
                cmd.finish = 1'b1;
              end else begin
                cmd.k_op   = K_ZERO;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RS_K;
                state_nxt  = S_SCAN;
              end
            end
            default: begin
              // Unused codes report the unchanged state.
              cmd.finish = 1'b1;
            end
          endcase
        end
      end

      // Compare one entry per cycle while the next one is being read.
      S_SCAN: begin
        if (stat.match) begin
          cmd.res_set = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RS_K1;
          state_nxt   = S_SHIFT;
        end else if (stat.k_last) begin
          cmd.st_set = 1'b1;
          cmd.st_val = ST_NOT_FOUND;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.k_op   = K_INC;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_K;
        end
      end

      // Move the later entries forward, one per cycle.
      S_SHIFT: begin
        if (!stat.k_last) begin
          cmd.shift_wr = 1'b1;
          cmd.k_op     = K_INC;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RS_K1;
        end else if (stat.cnt_one) begin
          cmd.rm_dec = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rm_dec = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_FRONT;
          state_nxt  = S_RD_BOTH;
        end
      end

      // Load the new front value and read the new back value.
      S_RD_BOTH: begin
        cmd.ld_front = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RS_BACK;
        state_nxt    = S_RD_BACK;
      end

      S_RD_FRONT: begin
        cmd.ld_front = 1'b1;
        cmd.finish   = 1'b1;
        state_nxt    = S_IDLE;
      end

      S_RD_BACK: begin
        cmd.ld_back = 1'b1;
        cmd.finish  = 1'b1;
        state_nxt   = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: controller plus datapath.
// Depends on dq_pkg, dq_ctrl, dq_datapath and dq_ram.
`default_nettype none

// A request is taken at a rising edge with start high and busy low. Its result
// appears on out_item for exactly one cycle with out_valid high, in the cycle
// after the request's last cycle, and the receiver cannot stall it. A push
// finishes in the cycle in which it is taken, so a new request may follow at
// once. Pops that leave entries behind pass through S_RD_FRONT or S_RD_BACK,
// because the new end value is read from the single read port of the entry
// store; a pop that empties the store or finds it empty finishes at once.
// Remove compares one entry per cycle from the front, then moves the later
// entries forward one per cycle over the same port, then rereads both end
// values (S_RD_BOTH, S_RD_BACK) unless it took out the only entry. When not
// found it ends with the last compare; on an empty store it finishes at once.
// The store holds DEPTH entries of VALUE_BITS bits; values are kept and
// compared in their low VALUE_BITS bits and shown on the 32-bit result fields
// zero-extended or truncated. No clearing pass is needed after reset.
module double_ended_queue_unit
  import dq_pkg::*;
#(
  parameter int DEPTH      = DQ_DEPTH,
  parameter int VALUE_BITS = DQ_VALUE_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item
);

  dq_cmd_t  cmd;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> tb/sv/double_ended_queue_unit_check.sv
`timescale 1ns / 100ps
// Checker for the double-ended queue unit: tracks the queue contents, predicts each result
// and compares it with what the unit reports. Depends on dq_pkg only.
`default_nettype none

module double_ended_queue_unit_check
  import dq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire in_item_t  in_item,
  input  wire logic      out_valid,
  input  wire out_item_t out_item,
  output int             fail_count,
  output int             pending,
  output int             compared,
  output int             full_refusals,
  output int             removes_found
);

  localparam int RING = DQ_DEPTH;

  // Shadow copy of the ring, its front position and fill level.
  logic [DQ_VAL_W-1:0] ring_vals [RING];
  logic [3:0]          head;
  logic [DQ_LEN_W-1:0] fill;

  // Outcomes of accepted requests that have not been reported yet.
  out_item_t pending_outcomes [$];

  // Apply one request to the shadow queue and return the outcome it should give.
  function automatic out_item_t deque_apply(input in_item_t req);
    out_item_t           res;
    logic [DQ_VAL_W-1:0] val;
    logic [3:0]          slot;
    bit                  hit;
    val = req.item_value;
    res = '0;
    res.status = ST_OK;
    hit = 1'b0;
    case (req.opcode)
      OP_PUSH_BACK: begin
        if (fill >= RING) begin
          res.status = ST_FULL;
        end else begin
          slot = 4'(head + fill);
          ring_vals[slot] = val;
          fill++;
        end
      end
      OP_POP_BACK: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          fill--;
          res.out_value = ring_vals[4'(head + fill)];
        end
      end
      OP_PUSH_FRONT: begin
        if (fill >= RING) begin
          res.status = ST_FULL;
        end else begin
          head = head - 4'd1;
          ring_vals[head] = val;
          fill++;
        end
      end
      OP_POP_FRONT: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_value = ring_vals[head];
          head = head + 4'd1;
          fill--;
        end
      end
      OP_REMOVE: begin
        res.status = ST_NOT_FOUND;
        // The first match from the front is taken out and later entries close up.
        for (int k = 0; k < fill; k++) begin
          if (!hit && ring_vals[4'(head + k)] == val) begin
            hit = 1'b1;
            res.out_value = val;
            res.status = ST_OK;
            for (int j = k; j + 1 < fill; j++) begin
              ring_vals[4'(head + j)] = ring_vals[4'(head + j + 1)];
            end
          end
        end
        if (hit) begin
          fill--;
        end
      end
      default: begin
        // Spare opcodes leave everything as it is.
      end
    endcase
    res.length = fill;
    res.front_value = (fill != 0) ? ring_vals[head] : '0;
    res.back_value = (fill != 0) ? ring_vals[4'(head + fill - 1)] : '0;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [DQ_VAL_W-1:0] exp_val,
                             input logic [DQ_VAL_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Results are compared before a request taken at the same edge is predicted,
  // since that result always belongs to an older request.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      head = '0;
      fill = '0;
      pending_outcomes.delete();
      fail_count = 0;
      pending <= 0;
      compared = 0;
      full_refusals = 0;
      removes_found = 0;
    end else begin
      if (out_valid) begin
        if (pending_outcomes.size() == 0) begin
          $error("result with no request outstanding: %p", out_item);
          fail_count++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("out_value", want.out_value, out_item.out_value);
          check_field("status", 32'(want.status), 32'(out_item.status));
          check_field("length", 32'(want.length), 32'(out_item.length));
          check_field("front_value", want.front_value, out_item.front_value);
          check_field("back_value", want.back_value, out_item.back_value);
          compared++;
        end
      end
      if (start && !busy) begin
        want = deque_apply(in_item);
        if (want.status == ST_FULL) begin
          full_refusals++;
        end
        if (in_item.opcode == OP_REMOVE && want.status == ST_OK) begin
          removes_found++;
        end
        pending_outcomes.push_back(want);
      end
      pending <= pending_outcomes.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/double_ended_queue_unit_test.sv
`timescale 1ns / 100ps
// Top of the double-ended queue unit testbench: clock, reset, request stimulus and verdict.
// Depends on dq_pkg, double_ended_queue_unit and double_ended_queue_unit_check.
`default_nettype none

module double_ended_queue_unit_test;
  import dq_pkg::*;

  // Opcodes outside the defined set, which the unit treats as no operation.
  localparam logic [DQ_OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [DQ_OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam int RANDOM_ITEMS   = 500;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int POOL_SIZE      = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  int fail_count;
  int pending;
  int compared;
  int full_refusals;
  int removes_found;

  int  sent = 0;
  int  idle_cycles = 0;
  bit  burst = 1'b0;
  logic [DQ_VAL_W-1:0] value_pool [POOL_SIZE];

  always #2 clk = ~clk;

  double_ended_queue_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  double_ended_queue_unit_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .fail_count   (fail_count),
    .pending      (pending),
    .compared     (compared),
    .full_refusals(full_refusals),
    .removes_found(removes_found)
  );

  // Stop the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Issue one request after a random gap (none in burst phases) and hold it until the unit takes it.
  task automatic issue(input logic [DQ_OP_W-1:0] op, input logic [DQ_VAL_W-1:0] val);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= '{opcode: op, item_value: val};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  function automatic logic [DQ_VAL_W-1:0] pick_value(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) begin
      return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return $urandom();
  endfunction

  initial begin
    int phase_left;
    int mode;
    int roll;
    int push_pct;
    int pop_pct;
    int remove_pct;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, value extremes, both ends, removal and spare opcodes.
    issue(OP_POP_BACK, 32'h0);
    issue(OP_POP_FRONT, 32'h0);
    issue(OP_REMOVE, 32'h0);
    issue(OP_PUSH_BACK, 32'h0000_0000);
    issue(OP_PUSH_BACK, 32'hFFFF_FFFF);
    issue(OP_PUSH_FRONT, 32'h8000_0000);
    issue(OP_PUSH_FRONT, 32'h0000_0001);
    issue(OP_REMOVE, 32'hFFFF_FFFF);
    issue(OP_REMOVE, 32'h1234_5678);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      issue(DQ_OP_W'(op), 32'hA5A5_5A5A);
    end
    issue(OP_REMOVE, 32'h0000_0001);
    issue(OP_POP_BACK, 32'h0);
    issue(OP_POP_FRONT, 32'h0);
    issue(OP_POP_FRONT, 32'h0);

    // Random phases lean toward filling, draining or a balanced mix, with values
    // drawn mostly from a small pool so that removals find matches.
    phase_left = 0;
    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 50);
        mode = $urandom_range(0, 2);
        burst = ($urandom_range(0, 2) == 0);
        foreach (value_pool[i]) begin
          value_pool[i] = $urandom();
        end
      end
      phase_left--;
      case (mode)
        0: begin push_pct = 70; pop_pct = 15; remove_pct = 12; end
        1: begin push_pct = 20; pop_pct = 55; remove_pct = 22; end
        default: begin push_pct = 40; pop_pct = 30; remove_pct = 27; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        issue($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value(70));
      end else if (roll < push_pct + pop_pct) begin
        issue($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, $urandom());
      end else if (roll < push_pct + pop_pct + remove_pct) begin
        issue(OP_REMOVE, pick_value(80));
      end else begin
        issue(DQ_OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), $urandom());
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d requests; %0d results compared.", sent, compared);
    $display("Refused pushes on a full queue: %0d; removals that found a match: %0d.",
             full_refusals, removes_found);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_datapath.sv
sv/dq_ctrl.sv
sv/double_ended_queue_unit.sv
tb/sv/double_ended_queue_unit_check.sv
tb/sv/double_ended_queue_unit_test.sv
